// File: sv/i2c_ras_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_ras_pkg
// shared types and codes for the i2c 16-bit register access sequencer
// ----------------------------------------------------------------------------
package i2c_ras_pkg;

	// configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic [0:0] REG_POLL_LIMIT = 1'b0;
	localparam logic [15:0] POLL_LIMIT_RST = 16'd10000;

	// byte core command bits
	localparam logic [15:0] CMD_START = 16'h0100;
	localparam logic [15:0] CMD_STOP  = 16'h0200;
	localparam logic [15:0] CMD_WRITE = 16'h0400;
	localparam logic [15:0] CMD_READ  = 16'h0800;
	localparam logic [15:0] CMD_NAK   = 16'h1000;

	// byte core status bits
	localparam int ST_TIP_BIT = 12;
	localparam int ST_NAK_BIT = 13;

	// request kinds
	localparam logic FUNC_REQ    = 1'b0;
	localparam logic FUNC_STATUS = 1'b1;

	typedef enum logic [1:0] {
		ACT_ISSUE  = 2'd0,
		ACT_POLL   = 2'd1,
		ACT_DONE   = 2'd2,
		ACT_IGNORE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_NAK     = 2'd1,
		ERR_TIMEOUT = 2'd2
	} err_t;

	typedef enum logic [9:0] {
		PH_IDLE   = 10'b00_0000_0001,
		PH_START  = 10'b00_0000_0010,
		PH_REGH   = 10'b00_0000_0100,
		PH_REGL   = 10'b00_0000_1000,
		PH_VALH   = 10'b00_0001_0000,
		PH_VALL   = 10'b00_0010_0000,
		PH_RSTART = 10'b00_0100_0000,
		PH_RD1    = 10'b00_1000_0000,
		PH_RD2    = 10'b01_0000_0000,
		PH_STOP   = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic        func;
		logic        is_read;
		logic [7:0]  slave_addr_byte;
		logic [15:0] register_addr;
		logic [15:0] write_value;
		logic [15:0] status_word;
	} req_t;

	typedef struct packed {
		action_t     action;
		logic [15:0] command_word;
		err_t        error_code;
		logic [15:0] read_value;
	} res_t;

	typedef struct packed {
		logic step;
		logic req_item;
		logic busy;
		logic fin;
	} stat_t;

endpackage

// File: sv/i2c_ras_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_ras_if
// valid/ready channels for access requests and results
// ----------------------------------------------------------------------------
interface i2c_ras_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic        is_read;
	logic [7:0]  slave_addr_byte;
	logic [15:0] register_addr;
	logic [15:0] write_value;
	logic [15:0] status_word;

	modport source (
		output valid, func, is_read, slave_addr_byte, register_addr, write_value,
			status_word,
		input  ready
	);
	modport sink (
		input  valid, func, is_read, slave_addr_byte, register_addr, write_value,
			status_word,
		output ready
	);
endinterface

interface i2c_ras_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] command_word;
	logic [1:0]  error_code;
	logic [15:0] read_value;

	modport source (
		output valid, action, command_word, error_code, read_value,
		input  ready
	);
	modport sink (
		input  valid, action, command_word, error_code, read_value,
		output ready
	);
endinterface

// File: sv/i2c_ras_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_ras_regs
// apb register file holding the status poll limit
// ----------------------------------------------------------------------------
module i2c_ras_regs
	import i2c_ras_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [15:0]       poll_limit
);

	logic [15:0] poll_limit_q;
	logic        sel_limit;

	assign pready    = 1'b1;
	assign sel_limit = (paddr[ADDR_W-1:2] == REG_POLL_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= POLL_LIMIT_RST;
		end else if (psel && penable && pwrite && pready && sel_limit) begin
			poll_limit_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_limit) begin
			prdata = {{(DATA_W-16){1'b0}}, poll_limit_q};
		end
	end

	assign poll_limit = poll_limit_q;

endmodule

// File: sv/i2c_ras_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_ras_seq
// access state and per-item decision: next command, poll, ignore or finish
// ----------------------------------------------------------------------------
module i2c_ras_seq
	import i2c_ras_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  req_t        item,
	input  logic [15:0] poll_limit,
	output res_t        res_d,
	output stat_t       stat
);

	phase_t      phase_q, phase_d;
	logic [15:0] poll_cnt_q, poll_cnt_d;
	logic        read_mode_q, read_mode_d;
	logic [7:0]  slave_q, slave_d;
	logic [15:0] reg_addr_q, reg_addr_d;
	logic [15:0] value_q, value_d;
	logic [7:0]  first_q, first_d;
	logic [16:0] cnt_inc;
	logic        tip;
	logic        nak;
	logic [7:0]  data;

	assign tip     = item.status_word[ST_TIP_BIT];
	assign nak     = item.status_word[ST_NAK_BIT];
	assign data    = item.status_word[7:0];
	assign cnt_inc = {1'b0, poll_cnt_q} + 17'd1;

	always_comb begin
		phase_d     = phase_q;
		poll_cnt_d  = poll_cnt_q;
		read_mode_d = read_mode_q;
		slave_d     = slave_q;
		reg_addr_d  = reg_addr_q;
		value_d     = value_q;
		first_d     = first_q;
		res_d       = '{action: ACT_IGNORE, command_word: 16'h0000,
			error_code: ERR_NONE, read_value: 16'h0000};

		if (item.func == FUNC_REQ) begin
			if (phase_q == PH_IDLE) begin
				read_mode_d = item.is_read;
				slave_d     = item.slave_addr_byte;
				reg_addr_d  = item.register_addr;
				value_d     = item.write_value;
				first_d     = 8'h00;
				phase_d     = PH_START;
				poll_cnt_d  = 16'h0000;
				res_d.action       = ACT_ISSUE;
				res_d.command_word = {8'h00, item.slave_addr_byte} | CMD_START | CMD_WRITE;
			end
		end else if (phase_q != PH_IDLE) begin
			if (tip) begin
				if (cnt_inc >= {1'b0, poll_limit}) begin
					phase_d          = PH_IDLE;
					poll_cnt_d       = 16'h0000;
					res_d.action     = ACT_DONE;
					res_d.error_code = ERR_TIMEOUT;
				end else begin
					poll_cnt_d   = cnt_inc[15:0];
					res_d.action = ACT_POLL;
				end
			end else begin
				poll_cnt_d   = 16'h0000;
				res_d.action = ACT_ISSUE;
				case (phase_q)
					PH_START: begin
						phase_d            = PH_REGH;
						res_d.command_word = {8'h00, reg_addr_q[15:8]} | CMD_WRITE;
					end
					PH_REGH: begin
						phase_d            = PH_REGL;
						res_d.command_word = {8'h00, reg_addr_q[7:0]} | CMD_WRITE;
					end
					PH_REGL: begin
						if (read_mode_q) begin
							phase_d            = PH_RSTART;
							res_d.command_word = {8'h00, slave_q[7:1], 1'b1}
								| CMD_START | CMD_WRITE;
						end else begin
							phase_d            = PH_VALH;
							res_d.command_word = {8'h00, value_q[15:8]} | CMD_WRITE;
						end
					end
					PH_VALH: begin
						phase_d            = PH_VALL;
						res_d.command_word = {8'h00, value_q[7:0]} | CMD_WRITE;
					end
					PH_VALL: begin
						phase_d            = PH_STOP;
						res_d.command_word = CMD_STOP;
					end
					PH_RSTART: begin
						phase_d            = PH_RD1;
						res_d.command_word = CMD_READ;
					end
					PH_RD1: begin
						first_d            = data;
						phase_d            = PH_RD2;
						res_d.command_word = CMD_READ | CMD_NAK;
					end
					PH_RD2: begin
						value_d            = {first_q, data};
						phase_d            = PH_STOP;
						res_d.command_word = CMD_STOP;
					end
					PH_STOP: begin
						phase_d          = PH_IDLE;
						res_d.action     = ACT_DONE;
						res_d.read_value = read_mode_q ? value_q : 16'h0000;
					end
					default: begin
						phase_d      = PH_IDLE;
						res_d.action = ACT_IGNORE;
					end
				endcase
				// a nak after start or a byte write ends the access, no stop
				if (nak && (phase_q == PH_START || phase_q == PH_REGH
						|| phase_q == PH_REGL || phase_q == PH_VALH
						|| phase_q == PH_VALL || phase_q == PH_RSTART)) begin
					phase_d            = PH_IDLE;
					value_d            = value_q;
					res_d.action       = ACT_DONE;
					res_d.command_word = 16'h0000;
					res_d.error_code   = ERR_NAK;
					res_d.read_value   = 16'h0000;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			poll_cnt_q  <= 16'h0000;
			read_mode_q <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			poll_cnt_q  <= poll_cnt_d;
			read_mode_q <= read_mode_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			slave_q    <= slave_d;
			reg_addr_q <= reg_addr_d;
			value_q    <= value_d;
			first_q    <= first_d;
		end
	end

	assign stat.step     = step;
	assign stat.req_item = (item.func == FUNC_REQ);
	assign stat.busy     = (phase_q != PH_IDLE);
	assign stat.fin      = (res_d.action == ACT_DONE);

endmodule

// File: sv/i2c_ras_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_reg16_access_sequencer
// sequences one 16-bit register read or write through a byte-level i2c core
// ----------------------------------------------------------------------------
// Each item on the req channel is either a new access request or a status
// word returned by the byte core, and each one yields exactly one result on
// the res channel: a command word to issue, a request to poll again, the end
// of the access (with error code and read value) or a note that the item was
// ignored. The block takes one item every clock cycle while its results are
// taken; an item's result is presented on the res channel after the item has
// passed through the input register, a single decision step and the result
// register, and the input register holds its item while a result waits.
// Because the input register can fill while a result waits, one more item is
// taken while the result side is stalled. poll_limit lives at apb address 0
// and should be changed only while no access is in progress.
module i2c_reg16_access_sequencer
	import i2c_ras_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	i2c_ras_req_if.sink       req,
	i2c_ras_res_if.source     res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [15:0] poll_limit;
	req_t        req_s1;
	logic        vld_s1;
	res_t        res_s2;
	logic        vld_s2;
	res_t        res_d;
	stat_t       stat;
	logic        adv;
	logic        take;

	// configuration registers
	i2c_ras_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.poll_limit (poll_limit)
	);

	// the input stage moves on when the result register is free or emptying
	assign adv       = vld_s1 && (!vld_s2 || res.ready);
	assign req.ready = !vld_s1 || adv;
	assign take      = req.valid && req.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= '{func: req.func, is_read: req.is_read,
				slave_addr_byte: req.slave_addr_byte, register_addr: req.register_addr,
				write_value: req.write_value, status_word: req.status_word};
		end
	end

	// sequencer state and decision
	i2c_ras_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.item       (req_s1),
		.poll_limit (poll_limit),
		.res_d      (res_d),
		.stat       (stat)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (res.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_d;
		end
	end

	assign res.valid        = vld_s2;
	assign res.action       = res_s2.action;
	assign res.command_word = res_s2.command_word;
	assign res.error_code   = res_s2.error_code;
	assign res.read_value   = res_s2.read_value;

`ifndef ASSERT_OFF
	// a finished access always leaves the sequencer idle
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stat.step && stat.fin |=> !stat.busy)
		else $error("sequencer still busy after finishing an access");

	// a request taken while idle always starts an access
	a_req_start: assert property (@(posedge clk) disable iff (!arst_n)
		stat.step && stat.req_item && !stat.busy |=> stat.busy)
		else $error("request while idle did not start an access");

	// every decision step lands in the result register
	a_step_res: assert property (@(posedge clk) disable iff (!arst_n)
		stat.step |=> res.valid)
		else $error("decision step produced no result");
`endif

endmodule
